@@ design/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the LED strip layer compositor
// Transaction payloads, command codes, pixel type and position clamp.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int PIXELS         = 8;
	localparam int POSITION_LIMIT = 20;
	localparam int IDX_W          = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	// command codes
	localparam logic [2:0] OP_CLEAR     = 3'd0;
	localparam logic [2:0] OP_BLEND_ALL = 3'd1;
	localparam logic [2:0] OP_BLEND_PIX = 3'd2;
	localparam logic [2:0] OP_MAX       = 3'd3;
	localparam logic [2:0] OP_GRADIENT  = 3'd4;
	localparam logic [2:0] OP_BRUSH     = 3'd5;
	localparam logic [2:0] OP_ROTATE    = 3'd6;
	localparam logic [2:0] OP_EMIT      = 3'd7;

	typedef struct packed {
		logic [2:0]        op;
		logic signed [7:0] pos_a;
		logic signed [7:0] pos_b;
		logic [7:0]        red_a;
		logic [7:0]        green_a;
		logic [7:0]        blue_a;
		logic [7:0]        alpha_a;
		logic [7:0]        red_b;
		logic [7:0]        green_b;
		logic [7:0]        blue_b;
		logic [7:0]        alpha_b;
	} in_item_t;

	typedef struct packed {
		logic [2:0] pixel_index;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_pixel;
	} out_item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// clamp a widened position to +-POSITION_LIMIT
	function automatic logic signed [7:0] clamp_pos(input logic signed [9:0] p);
		logic signed [9:0] lim;
		lim = 10'(POSITION_LIMIT);
		if (p > lim)
			return 8'(lim);
		else if (p < -lim)
			return 8'(-lim);
		else
			return p[7:0];
	endfunction

endpackage

@@ design/lsc_blend.sv @@
// ----------------------------------------------------------------------------
// lsc_blend: eight-bit alpha over blend of one pixel
// new = (c*a >> 8) + (old*(255-a) >> 8) on each channel.
// ----------------------------------------------------------------------------
module lsc_blend (
	input  lsc_pkg::rgb_t color,
	input  logic [7:0]    alpha,
	input  lsc_pkg::rgb_t old,
	output lsc_pkg::rgb_t result
);
	import lsc_pkg::*;

	logic [7:0] inv_a;

	function automatic logic [7:0] over(input logic [7:0] c, input logic [7:0] a,
			input logic [7:0] ia, input logic [7:0] o);
		logic [15:0] p1;
		logic [15:0] p2;
		logic [8:0]  s;
		p1 = c * a;
		p2 = o * ia;
		s  = {1'b0, p1[15:8]} + {1'b0, p2[15:8]};
		return s[7:0];
	endfunction

	// per-channel blend, sum never exceeds 254
	always_comb begin
		inv_a    = 8'hFF - alpha;
		result.r = over(color.r, alpha, inv_a, old.r);
		result.g = over(color.g, alpha, inv_a, old.g);
		result.b = over(color.b, alpha, inv_a, old.b);
	end

endmodule

@@ design/lsc_slope_div.sv @@
// ----------------------------------------------------------------------------
// lsc_slope_div: iterative signed divider for gradient slopes
// Restoring division, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module lsc_slope_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [8:0] num,
	input  logic [7:0]        den,
	output logic              done,
	output logic signed [8:0] slope
);
	import lsc_pkg::*;

	logic [3:0] cnt_q;
	logic [7:0] rem_q;
	logic [7:0] quo_q;
	logic       neg_q;
	logic       done_q;
	logic [8:0] trial;
	logic       ge;
	logic [8:0] diff;
	logic [8:0] mag;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[7]};
		ge    = trial >= {1'b0, den};
		diff  = trial - {1'b0, den};
		mag   = num[8] ? 9'(-num) : 9'(num);
	end

	// iteration control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 4'd8;
				rem_q <= '0;
				quo_q <= mag[7:0];
				neg_q <= num[8];
			end else if (cnt_q != '0) begin
				quo_q <= {quo_q[6:0], ge};
				rem_q <= ge ? diff[7:0] : trial[7:0];
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1)
					done_q <= 1'b1;
			end
		end
	end

	assign done  = done_q;
	assign slope = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

@@ design/led_strip_layer_compositor.sv @@
// ----------------------------------------------------------------------------
// led_strip_layer_compositor: layered RGB compositor for a short LED strip
// Sequencer over a pixel store, one shared blend unit and a slope divider.
// ----------------------------------------------------------------------------
// Per command: clear, blend all and max pass over every pixel; blend pixel
//   writes one pixel, none when the index is off the strip.
// Gradient: a setup step, then 4 slope divisions (none when the clamped ends
//   meet), then a step over each position in the clamped span (at most
//   2*POSITION_LIMIT+1); brush runs two of these.
// Rotate: offset reduction into the strip, then a scaling and a move pass.
// Emit: one pixel a cycle through the output register while out_stall is low,
//   then a closing step once the last pixel is taken.
// No new transaction is taken until the command ends; reset clears the store.
module led_strip_layer_compositor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lsc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output lsc_pkg::out_item_t out_item
);
	import lsc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_PASS, ST_ONE, ST_GR_SETUP, ST_GR_DIVS, ST_GR_DIVW,
		ST_GR_RUN, ST_ROT_MOD, ST_ROT_SCALE, ST_ROT_MOVE, ST_EMIT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);

	state_t            state_q;
	in_item_t          item_q;
	logic [IDX_W-1:0]  j_q;
	logic              phase_q;
	logic signed [7:0] gi_q;
	logic signed [7:0] gp2_q;
	logic signed [10:0] col_q [4];
	logic [7:0]        gc2_q [4];
	logic signed [8:0] slope_q [4];
	logic [1:0]        k_q;
	logic signed [8:0] rot_q;
	logic [IDX_W-1:0]  src_q;
	logic [2:0]        pix_q;
	logic              out_valid_q;
	out_item_t         out_q;

	rgb_t              store_q [PIXELS];
	rgb_t              tmp_q [PIXELS];

	// store read and write port
	logic [IDX_W-1:0]  rd_idx;
	rgb_t              rd_pix;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	rgb_t              wr_pix;

	// blend unit inputs
	rgb_t              bl_color;
	logic [7:0]        bl_alpha;
	rgb_t              bl_result;
	rgb_t              max_pix;

	// gradient setup
	logic signed [9:0] rp1;
	logic signed [9:0] rp2;
	logic signed [7:0] cp1;
	logic signed [7:0] cp2;
	logic              swap;
	logic [7:0]        ca [4];
	logic [7:0]        cb [4];
	logic              on_strip;
	logic              pix_ok;

	// divider
	logic              div_start;
	logic signed [8:0] div_num;
	logic [7:0]        div_den;
	logic              div_done;
	logic signed [8:0] div_slope;

	assign rd_pix = store_q[rd_idx];
	assign on_strip = (gi_q >= 8'sd0) && (gi_q < $signed(8'(PIXELS)));
	assign pix_ok = (in_item.pos_a >= 8'sd0) && (in_item.pos_a < $signed(8'(PIXELS)));

	// read address and blend operand selection
	always_comb begin
		rd_idx   = j_q;
		bl_color = '{r: item_q.red_a, g: item_q.green_a, b: item_q.blue_a};
		bl_alpha = item_q.alpha_a;
		unique case (state_q)
			ST_ONE:    rd_idx = item_q.pos_a[IDX_W-1:0];
			ST_GR_RUN: begin
				rd_idx   = gi_q[IDX_W-1:0];
				bl_color = '{r: col_q[0][7:0], g: col_q[1][7:0], b: col_q[2][7:0]};
				bl_alpha = col_q[3][7:0];
			end
			ST_ROT_SCALE: begin
				bl_color = rd_pix;
				bl_alpha = 8'hFF;
			end
			default: ;
		endcase
		max_pix.r = (item_q.red_a   > rd_pix.r) ? item_q.red_a   : rd_pix.r;
		max_pix.g = (item_q.green_a > rd_pix.g) ? item_q.green_a : rd_pix.g;
		max_pix.b = (item_q.blue_a  > rd_pix.b) ? item_q.blue_a  : rd_pix.b;
	end

	lsc_blend u_blend (
		.color  (bl_color),
		.alpha  (bl_alpha),
		.old    (rd_pix),
		.result (bl_result)
	);

	// store write selection
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = j_q;
		wr_pix = bl_result;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en  = 1'b1;
				wr_pix = '0;
			end
			ST_PASS: begin
				wr_en = 1'b1;
				if (item_q.op == OP_MAX)
					wr_pix = max_pix;
			end
			ST_ONE: begin
				wr_en  = 1'b1;
				wr_idx = item_q.pos_a[IDX_W-1:0];
			end
			ST_GR_RUN: begin
				wr_en  = on_strip;
				wr_idx = gi_q[IDX_W-1:0];
			end
			ST_ROT_MOVE: begin
				wr_en  = 1'b1;
				wr_pix = tmp_q[src_q];
			end
			default: ;
		endcase
	end

	// gradient end points: clamp, then order
	always_comb begin
		ca[0] = item_q.red_a;
		ca[1] = item_q.green_a;
		ca[2] = item_q.blue_a;
		ca[3] = item_q.alpha_a;
		rp1   = 10'(item_q.pos_a);
		if (item_q.op == OP_BRUSH) begin
			cb[0] = item_q.red_a;
			cb[1] = item_q.green_a;
			cb[2] = item_q.blue_a;
			cb[3] = {1'b0, item_q.alpha_a[7:1]};
			rp2   = phase_q ? 10'(item_q.pos_a) - 10'(item_q.pos_b)
			                : 10'(item_q.pos_a) + 10'(item_q.pos_b);
		end else begin
			cb[0] = item_q.red_b;
			cb[1] = item_q.green_b;
			cb[2] = item_q.blue_b;
			cb[3] = item_q.alpha_b;
			rp2   = 10'(item_q.pos_b);
		end
		cp1  = clamp_pos(rp1);
		cp2  = clamp_pos(rp2);
		swap = cp1 > cp2;
	end

	// slope division of one component at a time
	assign div_start = (state_q == ST_GR_DIVS);
	assign div_num   = $signed({1'b0, gc2_q[k_q]}) - $signed({1'b0, col_q[k_q][7:0]});
	assign div_den   = 8'(gp2_q - gi_q);

	lsc_slope_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.slope  (div_slope)
	);

	// pixel store, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIXELS; i++)
				store_q[i] <= '0;
		end else if (wr_en) begin
			store_q[wr_idx] <= wr_pix;
		end
	end

	// rotate staging buffer
	always_ff @(posedge clk) begin
		if (state_q == ST_ROT_SCALE)
			tmp_q[j_q] <= bl_result;
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			phase_q     <= 1'b0;
			k_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					j_q     <= '0;
					phase_q <= 1'b0;
					if (in_valid) begin
						item_q <= in_item;
						case (in_item.op)
							OP_CLEAR:                state_q <= ST_CLEAR;
							OP_BLEND_ALL, OP_MAX:    state_q <= ST_PASS;
							OP_BLEND_PIX:            if (pix_ok) state_q <= ST_ONE;
							OP_GRADIENT, OP_BRUSH:   state_q <= ST_GR_SETUP;
							OP_ROTATE: begin
								rot_q   <= 9'(in_item.pos_a);
								state_q <= ST_ROT_MOD;
							end
							default: begin
								pix_q   <= '0;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_CLEAR, ST_PASS, ST_ROT_SCALE: begin
					j_q <= j_q + 1'b1;
					if (j_q == LAST_IDX) begin
						j_q     <= '0;
						state_q <= (state_q == ST_ROT_SCALE) ? ST_ROT_MOVE : ST_IDLE;
					end
				end
				ST_ONE: state_q <= ST_IDLE;
				ST_GR_SETUP: begin
					gi_q  <= swap ? cp2 : cp1;
					gp2_q <= swap ? cp1 : cp2;
					for (int k = 0; k < 4; k++) begin
						col_q[k]   <= 11'(swap ? cb[k] : ca[k]);
						gc2_q[k]   <= swap ? ca[k] : cb[k];
						slope_q[k] <= '0;
					end
					k_q     <= '0;
					state_q <= (cp1 == cp2) ? ST_GR_RUN : ST_GR_DIVS;
				end
				ST_GR_DIVS: state_q <= ST_GR_DIVW;
				ST_GR_DIVW: begin
					if (div_done) begin
						slope_q[k_q] <= div_slope;
						k_q          <= k_q + 2'd1;
						state_q      <= (k_q == 2'd3) ? ST_GR_RUN : ST_GR_DIVS;
					end
				end
				ST_GR_RUN: begin
					for (int k = 0; k < 4; k++)
						col_q[k] <= col_q[k] + 11'(slope_q[k]);
					gi_q <= gi_q + 8'sd1;
					if (gi_q == gp2_q) begin
						if (item_q.op == OP_BRUSH && !phase_q) begin
							phase_q <= 1'b1;
							state_q <= ST_GR_SETUP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ROT_MOD: begin
					if (rot_q < 9'sd0)
						rot_q <= rot_q + 9'(PIXELS);
					else if (rot_q >= $signed(9'(PIXELS)))
						rot_q <= rot_q - 9'(PIXELS);
					else begin
						src_q   <= rot_q[IDX_W-1:0];
						j_q     <= '0;
						state_q <= ST_ROT_SCALE;
					end
				end
				ST_ROT_MOVE: begin
					j_q   <= j_q + 1'b1;
					src_q <= (src_q == LAST_IDX) ? '0 : src_q + 1'b1;
					if (j_q == LAST_IDX) begin
						j_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						if (out_valid_q && out_q.last_pixel) begin
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							out_valid_q       <= 1'b1;
							out_q.pixel_index <= pix_q;
							out_q.red_out     <= rd_pix.r;
							out_q.green_out   <= rd_pix.g;
							out_q.blue_out    <= rd_pix.b;
							out_q.last_pixel  <= (j_q == LAST_IDX);
							pix_q             <= pix_q + 3'd1;
							j_q               <= (j_q == LAST_IDX) ? '0 : j_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef ASSERT_OFF
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT)
		else $error("result shown outside emit");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_item.last_pixel |=> !out_valid)
		else $error("result after last pixel");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.op != OP_BLEND_PIX |=> in_stall)
		else $error("command accepted without busy phase");
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_GR_DIVW)
		else $error("slope ready outside division wait");
`endif

endmodule

@@ sim/led_strip_layer_compositor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_layer_compositor_tb: self-checking bench of the strip compositor
// Drives directed and random commands, keeps a shadow pixel store and checks
// each emitted pixel against it, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module led_strip_layer_compositor_tb;
	import lsc_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int IN_W        = $bits(in_item_t);
	localparam int HOLD_LEN    = 300;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	led_strip_layer_compositor u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// shadow copy of the pixel store
	logic [7:0] shadow [PIXELS][3];
	out_item_t  pixels_due[$];
	int         n_errors;
	int         n_cycles = 0;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_cycles = 0;
	bit         hold_req;

	function automatic logic [7:0] over_blend(int c, int a, int prev);
		return 8'(((c * a) >> 8) + ((prev * (255 - a)) >> 8));
	endfunction

	function automatic void blend_into(int idx, int col[4]);
		if (idx < 0 || idx >= PIXELS)
			return;
		for (int k = 0; k < 3; k++)
			shadow[idx][k] = over_blend(col[k], col[3], shadow[idx][k]);
	endfunction

	function automatic int clamp_span(int p);
		if (p > POSITION_LIMIT)
			return POSITION_LIMIT;
		if (p < -POSITION_LIMIT)
			return -POSITION_LIMIT;
		return p;
	endfunction

	function automatic void run_gradient(int ca[4], int p1, int cb[4], int p2);
		int c1[4], c2[4], slope[4], col[4], t;
		p1 = clamp_span(p1);
		p2 = clamp_span(p2);
		if (p1 > p2) begin
			t = p1; p1 = p2; p2 = t;
			c1 = cb; c2 = ca;
		end else begin
			c1 = ca; c2 = cb;
		end
		for (int k = 0; k < 4; k++)
			slope[k] = (p2 > p1) ? (c2[k] - c1[k]) / (p2 - p1) : 0;
		for (int i = p1; i <= p2; i++) begin
			for (int k = 0; k < 4; k++)
				col[k] = c1[k] + (i - p1) * slope[k];
			blend_into(i, col);
		end
	endfunction

	// update the shadow store for one command and queue any emitted pixels
	function automatic void predict_command(in_item_t it);
		int pa, pb, src;
		int ca[4], cb[4], side[4];
		logic [7:0] snap [PIXELS][3];
		out_item_t px;
		pa = int'(it.pos_a);
		pb = int'(it.pos_b);
		ca = '{int'(it.red_a), int'(it.green_a), int'(it.blue_a), int'(it.alpha_a)};
		cb = '{int'(it.red_b), int'(it.green_b), int'(it.blue_b), int'(it.alpha_b)};
		case (it.op)
			OP_CLEAR: begin
				for (int i = 0; i < PIXELS; i++)
					for (int k = 0; k < 3; k++)
						shadow[i][k] = 8'd0;
			end
			OP_BLEND_ALL: begin
				for (int i = 0; i < PIXELS; i++)
					blend_into(i, ca);
			end
			OP_BLEND_PIX: blend_into(pa, ca);
			OP_MAX: begin
				for (int i = 0; i < PIXELS; i++)
					for (int k = 0; k < 3; k++)
						if (ca[k] > shadow[i][k])
							shadow[i][k] = 8'(ca[k]);
			end
			OP_GRADIENT: run_gradient(ca, pa, cb, pb);
			OP_BRUSH: begin
				side = ca;
				side[3] = ca[3] >> 1;
				run_gradient(ca, pa, side, pa + pb);
				run_gradient(ca, pa, side, pa - pb);
			end
			OP_ROTATE: begin
				snap = shadow;
				for (int i = 0; i < PIXELS; i++) begin
					src = ((i + pa) % PIXELS + PIXELS) % PIXELS;
					for (int k = 0; k < 3; k++)
						shadow[i][k] = over_blend(snap[src][k], 255, snap[i][k]);
				end
			end
			default: begin
				for (int i = 0; i < PIXELS; i++) begin
					px.pixel_index = 3'(i);
					px.red_out     = shadow[i][0];
					px.green_out   = shadow[i][1];
					px.blue_out    = shadow[i][2];
					px.last_pixel  = (i == PIXELS - 1);
					pixels_due.push_back(px);
				end
			end
		endcase
	endfunction

	function automatic in_item_t make_cmd(logic [2:0] op, int pa, int pb,
			logic [31:0] col_a, logic [31:0] col_b);
		in_item_t it;
		it.op = op;
		it.pos_a = 8'(pa);
		it.pos_b = 8'(pb);
		{it.red_a, it.green_a, it.blue_a, it.alpha_a} = col_a;
		{it.red_b, it.green_b, it.blue_b, it.alpha_b} = col_b;
		return it;
	endfunction

	function automatic in_item_t junk_item();
		return in_item_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
	endfunction

	// offer one transaction and wait until it is taken; entered at a falling
	// edge, returns at the falling edge after it is taken, payload still driven
	task automatic send_cmd(in_item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			in_item  <= junk_item();
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_command(it);
		@(negedge clk);
	endtask

	// withdraw the offer and drive junk on the payload
	task automatic idle_input();
		in_valid <= 1'b0;
		in_item  <= junk_item();
		@(negedge clk);
	endtask

	task automatic drain_results();
		idle_input();
		while (pixels_due.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	function automatic in_item_t random_cmd();
		in_item_t it;
		int r;
		it = junk_item();
		r = $urandom_range(99);
		if (r < 20)
			it.op = OP_EMIT;
		// mostly positions near the strip
		if ($urandom_range(3) != 0) begin
			it.pos_a = 8'($urandom_range(24) - 8);
			it.pos_b = 8'($urandom_range(24) - 12);
		end
		if ($urandom_range(4) == 0)
			it.alpha_a = ($urandom_range(1)) ? 8'd255 : 8'd0;
		return it;
	endfunction

	// receiver stall and result checking
	always @(negedge clk) begin
		if (hold_req && hold_cycles < HOLD_LEN) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else
			out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("led_strip_layer_compositor test failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_due.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected pixel %h", out_item);
			end else begin
				want = pixels_due.pop_front();
				if (out_item.pixel_index !== want.pixel_index ||
					out_item.red_out !== want.red_out ||
					out_item.green_out !== want.green_out ||
					out_item.blue_out !== want.blue_out ||
					out_item.last_pixel !== want.last_pixel) begin
					n_errors++;
					if (n_errors <= 10)
						$display("pixel mismatch: expected %h got %h", want, out_item);
				end
			end
		end
	end

	// directed rows: command, then the pixel expected first when known
	typedef struct {
		in_item_t  cmd;
		bit        known;
		out_item_t first;
	} dir_row_t;

	dir_row_t dir_rows[$];

	initial begin
		int phase_pct [4][2];
		n_errors = 0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		for (int i = 0; i < PIXELS; i++)
			for (int k = 0; k < 3; k++)
				shadow[i][k] = 8'd0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed part: store after reset, extremes, every command and corner
		dir_rows = '{
			'{make_cmd(OP_EMIT, 0, 0, 0, 0), 1, '{3'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
			'{make_cmd(OP_BLEND_ALL, 0, 0, 32'hffffffff, 0), 0, '0},
			'{make_cmd(OP_EMIT, 0, 0, 0, 0), 1, '{3'd0, 8'd254, 8'd254, 8'd254, 1'b0}},
			'{make_cmd(OP_CLEAR, 127, -128, 32'hffffffff, 32'hffffffff), 0, '0},
			'{make_cmd(OP_EMIT, 0, 0, 0, 0), 1, '{3'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
			'{make_cmd(OP_BLEND_PIX, 3, 0, 32'h80402080, 0), 0, '0},
			'{make_cmd(OP_BLEND_PIX, -1, 0, 32'hffffffff, 0), 0, '0},
			'{make_cmd(OP_BLEND_PIX, 8, 0, 32'hffffffff, 0), 0, '0},
			'{make_cmd(OP_BLEND_PIX, -128, 0, 32'hffffffff, 0), 0, '0},
			'{make_cmd(OP_MAX, 0, 0, 32'h10ff0000, 0), 0, '0},
			'{make_cmd(OP_EMIT, 0, 0, 0, 0), 0, '0},
			'{make_cmd(OP_GRADIENT, 0, 7, 32'hff0000ff, 32'h00ff0080), 0, '0},
			'{make_cmd(OP_GRADIENT, 6, 1, 32'h0000ffff, 32'hff000010), 0, '0},
			'{make_cmd(OP_GRADIENT, 4, 4, 32'h123456ff, 32'hffffffff), 0, '0},
			'{make_cmd(OP_GRADIENT, -128, 127, 32'hffffffff, 32'h00000000), 0, '0},
			'{make_cmd(OP_GRADIENT, 127, -128, 32'h000000ff, 32'hffffff00), 0, '0},
			'{make_cmd(OP_EMIT, 0, 0, 0, 0), 0, '0},
			'{make_cmd(OP_BRUSH, 3, 2, 32'h40c020ff, 0), 0, '0},
			'{make_cmd(OP_BRUSH, 4, -128, 32'hffffffff, 0), 0, '0},
			'{make_cmd(OP_BRUSH, 127, 127, 32'hffffffff, 0), 0, '0},
			'{make_cmd(OP_ROTATE, 3, 0, 0, 0), 0, '0},
			'{make_cmd(OP_ROTATE, -128, 0, 0, 0), 0, '0},
			'{make_cmd(OP_ROTATE, 127, 0, 0, 0), 0, '0},
			'{make_cmd(OP_EMIT, 0, 0, 0, 0), 0, '0}
		};
		foreach (dir_rows[r]) begin
			if (dir_rows[r].known) begin
				// typed-in expectation must agree with the shadow store
				if (shadow[0][0] !== dir_rows[r].first.red_out ||
					shadow[0][1] !== dir_rows[r].first.green_out ||
					shadow[0][2] !== dir_rows[r].first.blue_out) begin
					n_errors++;
					if (n_errors <= 10)
						$display("row %0d: store expected %h", r, dir_rows[r].first);
				end
			end
			send_cmd(dir_rows[r].cmd);
		end
		drain_results();

		// back-pressure: receiver holds off while commands keep coming
		hold_req = 1'b1;
		for (int n = 0; n < 6; n++)
			send_cmd(make_cmd(OP_EMIT, 0, 0, 0, 0));
		idle_input();
		while (hold_cycles < HOLD_LEN)
			@(negedge clk);
		hold_req = 1'b0;
		drain_results();

		// random phases: none, sender idle, receiver stall, both
		phase_pct = '{'{0, 0}, '{86, 0}, '{0, 86}, '{11, 11}};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_pct[ph][0];
			recv_stall_pct = phase_pct[ph][1];
			for (int n = 0; n < 100; n++) begin
				send_cmd(random_cmd());
				// once per phase, wait for every pixel before going on
				if (n == 50) begin
					idle_input();
					while (pixels_due.size() != 0)
						@(negedge clk);
				end
			end
		end
		send_cmd(make_cmd(OP_EMIT, 0, 0, 0, 0));
		recv_stall_pct = 0;
		drain_results();

		if (n_errors == 0)
			$display("led_strip_layer_compositor test passed");
		else
			$display("led_strip_layer_compositor test failed");
		$finish;
	end

endmodule
